// ===== sv/kmt_pkg.sv =====
// ----------------------------------------------------------------------------
// kmt_pkg
// Shared types, codes and sizes of the keyed message table.
// ----------------------------------------------------------------------------
package kmt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int MAX_RESULTS = 16;

    typedef enum logic [2:0] {
        FN_ADD     = 3'd0,
        FN_REMOVE  = 3'd1,
        FN_LOOKUP  = 3'd2,
        FN_SET_ACT = 3'd3,
        FN_LIST    = 3'd4,
        FN_CLEAR   = 3'd5
    } func_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_MISMATCH  = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef struct packed {
        logic [2:0]  func;
        logic [31:0] origin_station;
        logic [15:0] sequence_number;
        logic [31:0] sender_station;
        logic [15:0] message_handle;
        logic        active_value;
        logic [4:0]  max_count;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] found_handle;
        logic [3:0]  found_position;
        logic        released_valid;
        logic [15:0] released_handle;
        logic [4:0]  count;
        logic        last;
    } rsp_t;

    typedef struct packed {
        logic load;
        logic scan_step;
        logic apply;
        logic list_step;
        logic flush;
    } cmd_t;

    typedef struct packed {
        logic [2:0] func;
        logic       hit;
        logic       at_end;
        logic       list_end;
        logic       emit_mid;
    } stat_t;

endpackage

// ===== sv/kmt_ctrl.sv =====
// ----------------------------------------------------------------------------
// kmt_ctrl
// Controller that sequences the scan, the update and the result transfers.
// ----------------------------------------------------------------------------
module kmt_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    input  kmt_pkg::stat_t stat,
    output kmt_pkg::cmd_t  cmd
);

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_SCAN     = 5'b00010,
        S_LIST     = 5'b00100,
        S_OUT_MID  = 5'b01000,
        S_OUT_LAST = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   keyed_op;

    assign keyed_op = (stat.func == kmt_pkg::FN_ADD) || (stat.func == kmt_pkg::FN_REMOVE)
                   || (stat.func == kmt_pkg::FN_LOOKUP) || (stat.func == kmt_pkg::FN_SET_ACT);

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = (state_reg == S_OUT_MID) || (state_reg == S_OUT_LAST);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.func == kmt_pkg::FN_LIST)
                begin
                    state_next = S_LIST;
                end
                else if (!keyed_op || stat.hit || stat.at_end)
                begin
                    cmd.apply = 1'b1;
                    state_next = S_OUT_LAST;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_LIST:
            begin
                if (stat.list_end)
                begin
                    cmd.flush = 1'b1;
                    state_next = S_OUT_LAST;
                end
                else
                begin
                    cmd.list_step = 1'b1;
                    if (stat.emit_mid)
                    begin
                        state_next = S_OUT_MID;
                    end
                end
            end
            S_OUT_MID:
            begin
                if (!rsp_stall)
                begin
                    state_next = S_LIST;
                end
            end
            S_OUT_LAST:
            begin
                if (!rsp_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== sv/kmt_dp.sv =====
// ----------------------------------------------------------------------------
// kmt_dp
// Datapath: entry storage, key compare, shift insert and remove, results.
// ----------------------------------------------------------------------------
module kmt_dp (
    input  logic           clk,
    input  logic           rst_n,
    input  kmt_pkg::req_t  req,
    input  kmt_pkg::cmd_t  cmd,
    output kmt_pkg::stat_t stat,
    output kmt_pkg::rsp_t  rsp
);

    localparam int TD    = kmt_pkg::TABLE_DEPTH;
    localparam int IDX_W = kmt_pkg::IDX_W;
    localparam int CNT_W = kmt_pkg::CNT_W;

    logic [31:0] ent_origin_reg [TD];
    logic [15:0] ent_seq_reg    [TD];
    logic [31:0] ent_sender_reg [TD];
    logic [15:0] ent_handle_reg [TD];
    logic        ent_active_reg [TD];

    logic [CNT_W-1:0] total_reg;
    logic [CNT_W-1:0] idx_reg;
    logic [4:0]       n_reg;
    kmt_pkg::req_t    item_reg;
    kmt_pkg::rsp_t    rsp_reg;
    kmt_pkg::rsp_t    rsp_next;
    logic             rsp_load;
    logic             pend_valid_reg;
    logic [15:0]      pend_handle_reg;
    logic [3:0]       pend_pos_reg;
    logic [4:0]       pend_cnt_reg;

    logic [IDX_W-1:0] sel;
    logic             in_range;
    logic             hit;
    logic             emit;
    logic [4:0]       limit;
    logic [3:0]       pos4;

    assign sel      = idx_reg[IDX_W-1:0];
    assign pos4     = 4'(idx_reg);
    assign in_range = (idx_reg < total_reg);
    assign hit      = in_range && (ent_origin_reg[sel] == item_reg.origin_station)
                   && (ent_seq_reg[sel] == item_reg.sequence_number);
    assign limit    = (item_reg.max_count > 5'(kmt_pkg::MAX_RESULTS))
                    ? 5'(kmt_pkg::MAX_RESULTS) : item_reg.max_count;
    assign emit     = ent_active_reg[sel] && pend_valid_reg;
    assign rsp_load = cmd.apply || cmd.flush || (cmd.list_step && emit);

    assign stat.func     = item_reg.func;
    assign stat.hit      = hit;
    assign stat.at_end   = !in_range;
    assign stat.list_end = !in_range || (n_reg == limit);
    assign stat.emit_mid = emit;
    assign rsp           = rsp_reg;

    always_comb
    begin
        rsp_next      = '0;
        rsp_next.last = 1'b1;
        if (cmd.list_step)
        begin
            rsp_next.last           = 1'b0;
            rsp_next.found_handle   = pend_handle_reg;
            rsp_next.found_position = pend_pos_reg;
            rsp_next.count          = pend_cnt_reg;
        end
        else if (cmd.flush)
        begin
            if (pend_valid_reg)
            begin
                rsp_next.found_handle   = pend_handle_reg;
                rsp_next.found_position = pend_pos_reg;
                rsp_next.count          = pend_cnt_reg;
            end
        end
        else
        begin
            case (item_reg.func)
                kmt_pkg::FN_ADD:
                begin
                    if (hit)
                    begin
                        rsp_next.found_position = pos4;
                        if (ent_sender_reg[sel] != item_reg.sender_station)
                        begin
                            rsp_next.status = kmt_pkg::ST_MISMATCH;
                        end
                        else
                        begin
                            rsp_next.released_valid  = 1'b1;
                            rsp_next.released_handle = ent_handle_reg[sel];
                        end
                    end
                    else if (total_reg == CNT_W'(TD))
                    begin
                        rsp_next.status = kmt_pkg::ST_FULL;
                    end
                end
                kmt_pkg::FN_REMOVE:
                begin
                    if (hit)
                    begin
                        rsp_next.found_position  = pos4;
                        rsp_next.released_valid  = 1'b1;
                        rsp_next.released_handle = ent_handle_reg[sel];
                    end
                end
                kmt_pkg::FN_LOOKUP:
                begin
                    if (hit)
                    begin
                        rsp_next.found_handle   = ent_handle_reg[sel];
                        rsp_next.found_position = pos4;
                    end
                    else
                    begin
                        rsp_next.status = kmt_pkg::ST_NOT_FOUND;
                    end
                end
                kmt_pkg::FN_SET_ACT:
                begin
                    if (hit)
                    begin
                        rsp_next.found_position = pos4;
                    end
                    else
                    begin
                        rsp_next.status = kmt_pkg::ST_NOT_FOUND;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg      <= '0;
            idx_reg        <= '0;
            n_reg          <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                idx_reg        <= '0;
                n_reg          <= '0;
                pend_valid_reg <= 1'b0;
            end
            if (cmd.scan_step)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.list_step)
            begin
                idx_reg <= idx_reg + 1'b1;
                if (ent_active_reg[sel])
                begin
                    n_reg          <= n_reg + 1'b1;
                    pend_valid_reg <= 1'b1;
                end
            end
            if (cmd.apply)
            begin
                case (item_reg.func)
                    kmt_pkg::FN_ADD:
                    begin
                        if (!hit && (total_reg != CNT_W'(TD)))
                        begin
                            total_reg <= total_reg + 1'b1;
                        end
                    end
                    kmt_pkg::FN_REMOVE:
                    begin
                        if (hit)
                        begin
                            total_reg <= total_reg - 1'b1;
                        end
                    end
                    kmt_pkg::FN_CLEAR:
                    begin
                        total_reg <= '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= req;
        end
        if (cmd.list_step && ent_active_reg[sel])
        begin
            pend_handle_reg <= ent_handle_reg[sel];
            pend_pos_reg    <= pos4;
            pend_cnt_reg    <= n_reg + 1'b1;
        end
        if (rsp_load)
        begin
            rsp_reg <= rsp_next;
        end
        if (cmd.apply)
        begin
            case (item_reg.func)
                kmt_pkg::FN_ADD:
                begin
                    if (hit)
                    begin
                        if (ent_sender_reg[sel] == item_reg.sender_station)
                        begin
                            ent_handle_reg[sel] <= item_reg.message_handle;
                            ent_sender_reg[sel] <= item_reg.sender_station;
                        end
                    end
                    else if (total_reg != CNT_W'(TD))
                    begin
                        for (int i = 1; i < TD; i++)
                        begin
                            ent_origin_reg[i] <= ent_origin_reg[i-1];
                            ent_seq_reg[i]    <= ent_seq_reg[i-1];
                            ent_sender_reg[i] <= ent_sender_reg[i-1];
                            ent_handle_reg[i] <= ent_handle_reg[i-1];
                            ent_active_reg[i] <= ent_active_reg[i-1];
                        end
                        ent_origin_reg[0] <= item_reg.origin_station;
                        ent_seq_reg[0]    <= item_reg.sequence_number;
                        ent_sender_reg[0] <= item_reg.sender_station;
                        ent_handle_reg[0] <= item_reg.message_handle;
                        ent_active_reg[0] <= 1'b0;
                    end
                end
                kmt_pkg::FN_REMOVE:
                begin
                    if (hit)
                    begin
                        for (int i = 0; i < TD - 1; i++)
                        begin
                            if (i >= int'(idx_reg))
                            begin
                                ent_origin_reg[i] <= ent_origin_reg[i+1];
                                ent_seq_reg[i]    <= ent_seq_reg[i+1];
                                ent_sender_reg[i] <= ent_sender_reg[i+1];
                                ent_handle_reg[i] <= ent_handle_reg[i+1];
                                ent_active_reg[i] <= ent_active_reg[i+1];
                            end
                        end
                    end
                end
                kmt_pkg::FN_SET_ACT:
                begin
                    if (hit)
                    begin
                        ent_active_reg[sel] <= item_reg.active_value;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

// ===== sv/keyed_message_table_top.sv =====
// ----------------------------------------------------------------------------
// keyed_message_table_top
// Table of message entries keyed by origin station and sequence number.
// ----------------------------------------------------------------------------
// The block handles one request at a time and stalls requests until the last
// result transfer of the current one completes. One compare unit walks the
// entries one per cycle from the front, so a keyed request stops at the
// matching entry or, when there is no match, at the end of the table fill.
// A list request walks the entries one per cycle too, and pauses for each
// result transfer. Clear and unused codes skip the walk.
module keyed_message_table_top (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  kmt_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output kmt_pkg::rsp_t rsp
);

    kmt_pkg::cmd_t  cmd;
    kmt_pkg::stat_t stat;

    kmt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    kmt_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .stat  (stat),
        .rsp   (rsp)
    );

endmodule
